// ===== hdl/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  // pattern characters with a special meaning
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_ANY  = 8'h3F;

  // pattern storage held by the configuration registers
  localparam int REG_BYTES       = 32;
  localparam int REG_WORDS       = 4;
  localparam int WORD_W          = 64;
  localparam int LEN_W           = 6;
  localparam int MAX_PATTERN_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_D      = 3'd4;

  // per-transaction control broadcast to every cell
  typedef struct packed {
    logic       accept;
    logic       start;
    logic       consume;
    logic [7:0] text;
  } wpm_ctrl_t;

  // data handed from one cell to its right neighbor
  typedef struct packed {
    logic reload;  // initial column bit
    logic cur;     // column bit before the byte is consumed
    logic nxt;     // column bit after the byte is consumed
  } wpm_link_t;

endpackage

// ===== hdl/wpm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_cfg_regs
// Configuration register file: pattern length and the four pattern words.
// ----------------------------------------------------------------------------
module wpm_cfg_regs (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      wr_en,
  input  logic [wpm_pkg::CFG_IDX_W-1:0]             wr_index,
  input  logic [wpm_pkg::WORD_W-1:0]                wr_data,
  output logic [wpm_pkg::LEN_W-1:0]                 pat_len,
  output logic [wpm_pkg::REG_WORDS*wpm_pkg::WORD_W-1:0] pat_flat
);

  logic [wpm_pkg::LEN_W-1:0]  pat_len_r;
  logic [wpm_pkg::WORD_W-1:0] pat_a_r;
  logic [wpm_pkg::WORD_W-1:0] pat_b_r;
  logic [wpm_pkg::WORD_W-1:0] pat_c_r;
  logic [wpm_pkg::WORD_W-1:0] pat_d_r;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= '0;
      pat_a_r   <= '0;
      pat_b_r   <= '0;
      pat_c_r   <= '0;
      pat_d_r   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        wpm_pkg::CFG_PATTERN_LENGTH: pat_len_r <= wr_data[wpm_pkg::LEN_W-1:0];
        wpm_pkg::CFG_PATTERN_A:      pat_a_r   <= wr_data;
        wpm_pkg::CFG_PATTERN_B:      pat_b_r   <= wr_data;
        wpm_pkg::CFG_PATTERN_C:      pat_c_r   <= wr_data;
        wpm_pkg::CFG_PATTERN_D:      pat_d_r   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign pat_len  = pat_len_r;
  assign pat_flat = {pat_d_r, pat_c_r, pat_b_r, pat_a_r};

endmodule

// ===== hdl/wpm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds one column bit and updates it from its left
// neighbor, its own pattern byte and the current text byte.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wpm_pkg::wpm_ctrl_t ctrl,
  input  logic               en,        // position lies within the pattern
  input  logic [7:0]         pat_byte,
  input  wpm_pkg::wpm_link_t link_i,
  output wpm_pkg::wpm_link_t link_o,
  output logic               col_new    // column bit after this transaction
);

  logic col_r;
  logic col_nxt;
  logic is_star;
  logic is_match;

  // pattern byte classification
  assign is_star  = (pat_byte == wpm_pkg::CHAR_STAR);
  assign is_match = (pat_byte == wpm_pkg::CHAR_ANY) || (pat_byte == ctrl.text);

  // initial column, reload mux and byte update
  always_comb begin
    link_o.reload = en & link_i.reload & is_star;
    link_o.cur    = ctrl.start ? link_o.reload : col_r;
    if (!en) begin
      link_o.nxt = 1'b0;
    end else if (is_star) begin
      link_o.nxt = link_i.nxt | link_o.cur;
    end else if (is_match) begin
      link_o.nxt = link_i.cur;
    end else begin
      link_o.nxt = 1'b0;
    end
    col_nxt = ctrl.consume ? link_o.nxt : link_o.cur;
  end

  // stored column bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 1'b0;
    end else if (ctrl.accept) begin
      col_r <= col_nxt;
    end
  end

  assign col_new = col_nxt;

endmodule

// ===== hdl/wildcard_pattern_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_top
// Streams text bytes through a row of match cells, one per pattern position,
// and reports whether the whole wildcard pattern matches the text so far.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_text_byte, in_starts_text,
//                                          in_empty_query
//   out_     output     out_valid/out_stall out_whole_pattern_matches
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low: all cells update together,
// with star runs rippling through the row inside the cycle; the result sits
// in the output register in the cycle after acceptance.
// Reset clears the column to zero and all configuration registers.
// in_stall is raised while a result waits and out_stall is high.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_starts_text,
  input  logic                          in_empty_query,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_whole_pattern_matches,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wpm_pkg::WORD_W-1:0]    cfg_data
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int LIMIT_LEN =
    (MAX_PATTERN < wpm_pkg::REG_BYTES) ? MAX_PATTERN : wpm_pkg::REG_BYTES;

  logic [wpm_pkg::LEN_W-1:0]                         pat_len;
  logic [wpm_pkg::REG_WORDS*wpm_pkg::WORD_W-1:0]     pat_flat;
  logic [LW-1:0]                                     len_eff;
  wpm_pkg::wpm_ctrl_t                                ctrl;
  wpm_pkg::wpm_link_t                                link [MAX_PATTERN+1];
  logic [MAX_PATTERN:0]                              col_new;
  logic                                              col0_r;
  logic                                              accept;
  logic                                              out_valid_r;
  logic                                              out_valid_nxt;
  logic                                              out_match_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  wpm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .pat_len  (pat_len),
    .pat_flat (pat_flat)
  );

  // effective pattern length, saturated to the cell count and stored bytes
  assign len_eff = (pat_len > wpm_pkg::LEN_W'(LIMIT_LEN)) ? LW'(LIMIT_LEN)
                                                          : LW'(pat_len);

  // input handshake and control broadcast
  assign in_stall     = out_valid_r & out_stall;
  assign accept       = in_valid & ~in_stall;
  assign ctrl.accept  = accept;
  assign ctrl.start   = in_starts_text;
  assign ctrl.consume = ~in_empty_query;
  assign ctrl.text    = in_text_byte;

  // empty-prefix boundary bit
  assign link[0].reload = 1'b1;
  assign link[0].cur    = in_starts_text ? 1'b1 : col0_r;
  assign link[0].nxt    = 1'b0;
  assign col_new[0]     = in_empty_query ? link[0].cur : 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r <= 1'b0;
    end else if (accept) begin
      col0_r <= col_new[0];
    end
  end

  // row of match cells
  for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_cell
    logic [7:0] pbyte;
    logic       en;

    if (i <= wpm_pkg::REG_BYTES) begin : g_byte
      assign pbyte = pat_flat[8*(i-1) +: 8];
    end else begin : g_none
      assign pbyte = 8'h00;
    end

    assign en = ({1'b0, len_eff} >= (LW+1)'(i));

    wpm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .en       (en),
      .pat_byte (pbyte),
      .link_i   (link[i-1]),
      .link_o   (link[i]),
      .col_new  (col_new[i])
    );
  end

  // output register
  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_match_r <= col_new[len_eff];
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_whole_pattern_matches = out_match_r;

endmodule

// ===== verif/wpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_checker
// Watches the text, result and configuration channels of the wildcard
// pattern matcher. It keeps its own copy of the pattern registers and of the
// prefix match column, predicts the match bit of every accepted text
// transaction and compares it with the returned result in order.
// ----------------------------------------------------------------------------
module wpm_checker
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_starts_text,
  input  logic                 in_empty_query,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_whole_pattern_matches,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output int                   mismatch_count,
  output int                   pending_count
);

  // model copy of the registers and of the match column
  logic [LEN_W-1:0]    pat_len;
  logic [WORD_W-1:0]   pat_words [REG_WORDS];
  bit [MAX_PATTERN:0]  prefix_col;
  bit                  predicted_matches [$];
  int                  fails = 0;
  int                  waiting = 0;

  assign mismatch_count = fails;
  assign pending_count  = waiting;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  // length in use, saturated to the column size and the register storage
  function automatic int unsigned live_length();
    int unsigned n;
    n = pat_len;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    if (n > REG_BYTES) n = REG_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_char(input int unsigned k);
    return pat_words[k / 8][(k % 8) * 8 +: 8];
  endfunction

  // apply one transaction to the column and return the whole-pattern bit
  function automatic bit advance_column(input logic [7:0] c, input logic st,
                                        input logic em);
    int unsigned len;
    int unsigned i;
    bit [MAX_PATTERN:0] nxt;
    logic [7:0] pc;
    len = live_length();
    if (st) begin
      nxt = '0;
      nxt[0] = 1'b1;
      for (i = 1; i <= len; i++)
        nxt[i] = nxt[i-1] && (pattern_char(i - 1) == CHAR_STAR);
      prefix_col = nxt;
    end
    if (!em) begin
      nxt = '0;
      for (i = 1; i <= len; i++) begin
        pc = pattern_char(i - 1);
        // a star in the pattern stays a wildcard even against a star byte
        if (pc == CHAR_STAR)
          nxt[i] = nxt[i-1] | prefix_col[i];
        else if (pc == CHAR_ANY || pc == c)
          nxt[i] = prefix_col[i-1];
      end
      prefix_col = nxt;
    end
    return prefix_col[len];
  endfunction

  always @(posedge clk) begin
    bit exp_bit;
    int unsigned w;
    if (!rst_n) begin
      pat_len = '0;
      for (w = 0; w < REG_WORDS; w++) pat_words[w] = '0;
      prefix_col = '0;
      predicted_matches.delete();
    end else begin
      // text transaction uses the configuration from before this edge
      if (in_valid && !in_stall)
        predicted_matches.push_back(advance_column(in_text_byte, in_starts_text,
                                                   in_empty_query));
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (predicted_matches.size() == 0) begin
          report_mismatch($sformatf("result %b with no transaction pending",
                                    out_whole_pattern_matches));
        end else begin
          exp_bit = predicted_matches.pop_front();
          if (out_whole_pattern_matches !== exp_bit)
            report_mismatch($sformatf("whole_pattern_matches got %b expected %b",
                                      out_whole_pattern_matches, exp_bit));
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: pat_len      = cfg_data[LEN_W-1:0];
          CFG_PATTERN_A:      pat_words[0] = cfg_data;
          CFG_PATTERN_B:      pat_words[1] = cfg_data;
          CFG_PATTERN_C:      pat_words[2] = cfg_data;
          CFG_PATTERN_D:      pat_words[3] = cfg_data;
          default: ;
        endcase
      end
    end
    waiting <= predicted_matches.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the wildcard pattern matcher with a short directed sequence and then
// with random patterns and texts built to match them, some corrupted and
// some pure noise, under three idling regimes. The checker instance predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import wpm_pkg::*;

  localparam int ITEM_TARGET = 1550;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_text_byte = '0;
  logic                 in_starts_text = 1'b0;
  logic                 in_empty_query = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_whole_pattern_matches;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  int                   mismatch_count;
  int                   pending_count;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  logic [7:0]  pat_chars [REG_BYTES];
  int unsigned pat_used;
  bit          text_first;
  int          flip_countdown;

  wildcard_pattern_matcher_top dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_text_byte              (in_text_byte),
    .in_starts_text            (in_starts_text),
    .in_empty_query            (in_empty_query),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_whole_pattern_matches (out_whole_pattern_matches),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data)
  );

  wpm_checker chk (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_text_byte              (in_text_byte),
    .in_starts_text            (in_starts_text),
    .in_empty_query            (in_empty_query),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_whole_pattern_matches (out_whole_pattern_matches),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_index                 (cfg_index),
    .cfg_data                  (cfg_data),
    .mismatch_count            (mismatch_count),
    .pending_count             (pending_count)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // one text transaction, with idle cycles drawn cycle by cycle before it
  task automatic send_item(input logic [7:0] c, input logic st, input logic em);
    bit hit;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= c;
    in_starts_text <= st;
    in_empty_query <= em;
    do begin
      @(negedge clk);
      hit = !in_stall;
      @(posedge clk);
    end while (!hit);
    items_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
    bit hit;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do begin
      @(negedge clk);
      hit = cfg_ready;
      @(posedge clk);
    end while (!hit);
  endtask

  // write the length register and all four pattern words while idle
  task automatic program_pattern(input logic [LEN_W-1:0] len_reg);
    logic [CFG_IDX_W-1:0] word_reg [REG_WORDS];
    logic [WORD_W-1:0] w;
    int unsigned k;
    int unsigned b;
    word_reg[0] = CFG_PATTERN_A;
    word_reg[1] = CFG_PATTERN_B;
    word_reg[2] = CFG_PATTERN_C;
    word_reg[3] = CFG_PATTERN_D;
    drain();
    cfg_write(CFG_PATTERN_LENGTH, {{(WORD_W-LEN_W){1'b0}}, len_reg});
    for (k = 0; k < REG_WORDS; k++) begin
      for (b = 0; b < 8; b++) w[b*8 +: 8] = pat_chars[k*8 + b];
      cfg_write(word_reg[k], w);
    end
    cfg_valid <= 1'b0;
    pat_used = (len_reg > REG_BYTES) ? REG_BYTES : len_reg;
  endtask

  function automatic logic [7:0] pick_text_byte();
    case ($urandom_range(0, 7))
      0, 1:    return "a";
      2, 3:    return "b";
      4:       return "c";
      5:       return CHAR_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random pattern, unused bytes left random so every data bit toggles
  task automatic make_pattern(output logic [LEN_W-1:0] len_reg);
    int unsigned n;
    int unsigned k;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) n = $urandom_range(0, 8);
    else if (r < 88) n = $urandom_range(9, 20);
    else n = $urandom_range(21, REG_BYTES);
    for (k = 0; k < REG_BYTES; k++) begin
      pat_chars[k] = 8'($urandom_range(0, 255));
      if (k < n) begin
        r = $urandom_range(0, 9);
        if (r < 3) pat_chars[k] = CHAR_STAR;
        else if (r < 5) pat_chars[k] = CHAR_ANY;
        else if (r < 9) pat_chars[k] = 8'("a" + $urandom_range(0, 2));
      end
    end
    len_reg = LEN_W'(n);
    // overlong length saturates to the full pattern
    if (n == REG_BYTES && $urandom_range(0, 1)) len_reg = LEN_W'($urandom_range(33, 63));
  endtask

  // byte of a text, sometimes replaced, sometimes preceded by an empty query
  task automatic send_text_byte(input logic [7:0] c);
    if (flip_countdown == 0) c = pick_text_byte();
    flip_countdown--;
    if ($urandom_range(0, 9) == 0) begin
      send_item(8'($urandom_range(0, 255)), text_first, 1'b1);
      text_first = 1'b0;
    end
    send_item(c, text_first, 1'b0);
    text_first = 1'b0;
  endtask

  // text built by expanding the pattern, so it matches unless corrupted
  task automatic send_text(input bit corrupt);
    int unsigned k;
    int unsigned j;
    int unsigned n;
    text_first = 1'b1;
    flip_countdown = corrupt ? $urandom_range(0, 6) : -1;
    if ($urandom_range(0, 7) == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      text_first = 1'b0;
    end
    for (k = 0; k < pat_used; k++) begin
      if (pat_chars[k] == CHAR_STAR) begin
        n = $urandom_range(0, 3);
        for (j = 0; j < n; j++) send_text_byte(pick_text_byte());
      end else if (pat_chars[k] == CHAR_ANY) begin
        send_text_byte(pick_text_byte());
      end else begin
        send_text_byte(pat_chars[k]);
      end
    end
    if (text_first || $urandom_range(0, 3) == 0)
      send_item(8'($urandom_range(0, 255)), text_first, 1'b1);
  endtask

  // unstructured transactions
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n)
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                $urandom_range(0, 6) == 0);
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned target);
    logic [LEN_W-1:0] len_reg;
    int unsigned r;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (items_sent < target) begin
      make_pattern(len_reg);
      program_pattern(len_reg);
      repeat ($urandom_range(2, 5)) begin
        r = $urandom_range(0, 99);
        if (r < 15) send_noise();
        else send_text(r < 45);
        // hold off until the pipe is empty now and then
        if ($urandom_range(0, 19) == 0) drain();
      end
    end
  endtask

  initial begin
    int unsigned k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any start see an all-zero column
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h5A, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);

    // star against a star byte
    for (k = 0; k < REG_BYTES; k++) pat_chars[k] = 8'($urandom_range(0, 255));
    pat_chars[0] = "a";
    pat_chars[1] = CHAR_STAR;
    program_pattern(6'd2);
    send_item("a", 1'b1, 1'b0);
    send_item(CHAR_STAR, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);

    // overlong length with an all-star pattern
    for (k = 0; k < REG_BYTES; k++) pat_chars[k] = CHAR_STAR;
    program_pattern(6'd63);
    send_item(8'hA5, 1'b1, 1'b1);
    send_item(8'h80, 1'b0, 1'b0);

    // literal extremes around a single wildcard
    for (k = 0; k < REG_BYTES; k++) pat_chars[k] = 8'h00;
    pat_chars[0] = 8'hFF;
    pat_chars[1] = CHAR_ANY;
    pat_chars[2] = 8'h00;
    program_pattern(6'd3);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);

    // new pattern in the middle of a text keeps the old column
    pat_chars[0] = CHAR_ANY;
    program_pattern(6'd1);
    send_item(8'h7E, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b1);

    // empty pattern
    program_pattern(6'd0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hAA, 1'b1, 1'b0);

    run_phase(34, 57, 530);
    run_phase(57, 34, 1040);
    run_phase(0, 0, ITEM_TARGET);

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
